>>> rtl/core/srbs_pkg.sv
`timescale 1ns / 1ps
package srbs_pkg;

  localparam int TABLE_DEPTH  = 1024;
  localparam int RECORD_WORDS = 9;
  localparam int STORE_DEPTH  = TABLE_DEPTH * RECORD_WORDS;

  localparam int ENTRY_W    = $clog2(TABLE_DEPTH);
  localparam int COUNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int WORD_IDX_W = 4;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = $clog2(STORE_DEPTH);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // word 0 address of a record
  function automatic logic [ADDR_W-1:0] rec_base(input logic [ENTRY_W-1:0] e);
    rec_base = ADDR_W'(e) * ADDR_W'(RECORD_WORDS);
  endfunction

endpackage

>>> rtl/core/srbs_if.sv
`timescale 1ns / 1ps
interface srbs_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [srbs_pkg::ENTRY_W-1:0]      entry_index;
  logic [srbs_pkg::WORD_IDX_W-1:0]   word_index;
  logic [srbs_pkg::DATA_W-1:0]       word_value;
  logic [srbs_pkg::DATA_W-1:0]       codepoint;

  modport source (output valid, opcode, entry_index, word_index, word_value, codepoint,
                  input ready);
  modport sink (input valid, opcode, entry_index, word_index, word_value, codepoint,
                output ready);
endinterface

interface srbs_out_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [srbs_pkg::WORD_IDX_W-1:0]   word_position;
  logic [srbs_pkg::DATA_W-1:0]       record_word;
  logic                              last;

  modport source (output valid, found, word_position, record_word, last, input ready);
  modport sink (input valid, found, word_position, record_word, last, output ready);
endinterface

>>> rtl/core/srbs_store.sv
`timescale 1ns / 1ps
module srbs_store (
  input  logic                            clk,
  input  srbs_pkg::mem_req_t              mem_req,
  output logic [srbs_pkg::DATA_W-1:0]     rd_data
);

  logic [srbs_pkg::DATA_W-1:0] mem [0:srbs_pkg::STORE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data <= mem[mem_req.raddr];
    end
  end

endmodule

>>> rtl/core/srbs_ctrl.sv
`timescale 1ns / 1ps
module srbs_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  srbs_in_if.sink                         in_ch,
  srbs_out_if.source                      out_ch,
  input  logic [srbs_pkg::COUNT_W-1:0]    entry_count,
  output srbs_pkg::mem_req_t              mem_req,
  input  logic [srbs_pkg::DATA_W-1:0]     rd_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  localparam logic [srbs_pkg::WORD_IDX_W-1:0] LAST_WORD =
    srbs_pkg::WORD_IDX_W'(srbs_pkg::RECORD_WORDS - 1);

  logic [1:0] state, state_next;

  logic [srbs_pkg::DATA_W-1:0]     key, key_next;
  logic [srbs_pkg::COUNT_W-1:0]    start, start_next;
  logic [srbs_pkg::COUNT_W-1:0]    end_r, end_next;
  logic [srbs_pkg::COUNT_W-1:0]    pos, pos_next;
  logic [srbs_pkg::ADDR_W-1:0]     base, base_next;
  logic [srbs_pkg::WORD_IDX_W-1:0] word_cnt, word_cnt_next;

  logic                            out_valid, out_valid_next;
  logic                            out_found, out_found_next;
  logic [srbs_pkg::WORD_IDX_W-1:0] out_pos, out_pos_next;
  logic [srbs_pkg::DATA_W-1:0]     out_word, out_word_next;
  logic                            out_last, out_last_next;

  logic                            accept;
  logic                            out_free;
  logic                            key_less;
  logic [srbs_pkg::COUNT_W-1:0]    cmp_start, cmp_end, cmp_pos;
  logic                            cmp_in_range;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  assign in_ch.ready          = (state == ST_IDLE);
  assign out_ch.valid         = out_valid;
  assign out_ch.found         = out_found;
  assign out_ch.word_position = out_pos;
  assign out_ch.record_word   = out_word;
  assign out_ch.last          = out_last;

  // compare and interval update for the probe state
  always_comb begin
    key_less     = key < rd_data;
    cmp_start    = key_less ? start : pos + 1'b1;
    cmp_end      = key_less ? pos : end_r;
    cmp_pos      = cmp_start + ((cmp_end - cmp_start) >> 1);
    cmp_in_range = (cmp_pos >= cmp_start) && (cmp_pos < cmp_end);
  end

  always_comb begin
    state_next     = state;
    key_next       = key;
    start_next     = start;
    end_next       = end_r;
    pos_next       = pos;
    base_next      = base;
    word_cnt_next  = word_cnt;
    out_valid_next = out_valid && !out_ch.ready;
    out_found_next = out_found;
    out_pos_next   = out_pos;
    out_word_next  = out_word;
    out_last_next  = out_last;

    mem_req.we    = 1'b0;
    mem_req.waddr = srbs_pkg::rec_base(in_ch.entry_index)
                    + srbs_pkg::ADDR_W'(in_ch.word_index);
    mem_req.wdata = in_ch.word_value;
    mem_req.re    = 1'b0;
    mem_req.raddr = base;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.opcode == srbs_pkg::OP_WRITE) begin
            mem_req.we = in_ch.word_index < srbs_pkg::WORD_IDX_W'(srbs_pkg::RECORD_WORDS);
          end else begin
            key_next   = in_ch.codepoint;
            start_next = '0;
            end_next   = entry_count;
            pos_next   = entry_count >> 1;
            base_next  = srbs_pkg::rec_base(pos_next[srbs_pkg::ENTRY_W-1:0]);
            if (entry_count == '0) begin
              state_next = ST_MISS;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = base_next;
              state_next    = ST_CMP;
            end
          end
        end
      end
      ST_CMP: begin
        if (rd_data == key) begin
          // key word already in rd_data, it is word 0 of the result
          word_cnt_next = '0;
          state_next    = ST_EMIT;
        end else begin
          start_next = cmp_start;
          end_next   = cmp_end;
          pos_next   = cmp_pos;
          base_next  = srbs_pkg::rec_base(cmp_pos[srbs_pkg::ENTRY_W-1:0]);
          if (cmp_in_range) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = base_next;
          end else begin
            state_next = ST_MISS;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_found_next = 1'b1;
          out_pos_next   = word_cnt;
          out_word_next  = rd_data;
          out_last_next  = (word_cnt == LAST_WORD);
          if (word_cnt == LAST_WORD) begin
            state_next = ST_IDLE;
          end else begin
            word_cnt_next = word_cnt + 1'b1;
            mem_req.re    = 1'b1;
            mem_req.raddr = base + srbs_pkg::ADDR_W'(word_cnt_next);
          end
        end
      end
      ST_MISS: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_found_next = 1'b0;
          out_pos_next   = '0;
          out_word_next  = '0;
          out_last_next  = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key      <= key_next;
    start    <= start_next;
    end_r    <= end_next;
    pos      <= pos_next;
    base     <= base_next;
    word_cnt <= word_cnt_next;
    out_found <= out_found_next;
    out_pos  <= out_pos_next;
    out_word <= out_word_next;
    out_last <= out_last_next;
  end

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> (pos >= start) && (pos < end_r))
    else $error("probe outside search interval");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> word_cnt <= LAST_WORD)
    else $error("record word counter overran");

  a_found_last_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_found && out_last |-> out_pos == LAST_WORD)
    else $error("found record closed on wrong word");

  a_empty_miss: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.opcode == srbs_pkg::OP_LOOKUP && entry_count == '0
    |=> state == ST_MISS)
    else $error("empty table lookup did not miss");

endmodule

>>> rtl/core/sorted_record_binary_search.sv
`timescale 1ns / 1ps
// channel  | dir | transfer when        | payload
// in_ch    | in  | valid && ready       | opcode, entry_index, word_index, word_value, codepoint
// out_ch   | out | valid && ready       | found, word_position, record_word, last
// cfg      | in  | cfg_wr_en            | cfg_wr_data -> entry_count (saturates at table depth)
//
// a write stores one word in the record memory; a lookup issues one record-memory read per
// probe, at most 11 probes, then emits 9 result words for a hit or 1 for a miss
// the single read port of the record memory sets the probe and result-word rate
// rst is synchronous and clears the sequencer, output valid and entry_count; the memory
// is not cleared
// output stalls hold the sequencer; a new item is taken while the last result waits
module sorted_record_binary_search (
  input  logic                          clk,
  input  logic                          rst,
  srbs_in_if.sink                       in_ch,
  srbs_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [srbs_pkg::COUNT_W-1:0]  cfg_wr_data
);

  logic [srbs_pkg::COUNT_W-1:0] entry_count;
  logic [srbs_pkg::COUNT_W-1:0] entry_count_sat;
  srbs_pkg::mem_req_t           mem_req;
  logic [srbs_pkg::DATA_W-1:0]  rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  assign entry_count_sat =
    (entry_count > srbs_pkg::COUNT_W'(srbs_pkg::TABLE_DEPTH)) ?
    srbs_pkg::COUNT_W'(srbs_pkg::TABLE_DEPTH) : entry_count;

  srbs_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  srbs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .entry_count (entry_count_sat),
    .mem_req     (mem_req),
    .rd_data     (rd_data)
  );

endmodule

>>> bench/record_lookup_checker.sv
`timescale 1ns / 1ps
module record_lookup_checker
  import srbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  srbs_in_if                 in_ch,
  srbs_out_if                out_ch,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  output int                 errors,
  output int                 pending,
  output int                 hits,
  output int                 misses,
  output int                 writes
);

  typedef struct packed {
    logic                  found;
    logic [WORD_IDX_W-1:0] position;
    logic [DATA_W-1:0]     word;
    logic                  last;
  } result_word_t;

  logic [DATA_W-1:0]  table_copy [TABLE_DEPTH][RECORD_WORDS];
  logic [COUNT_W-1:0] entry_count;
  result_word_t       expected_words [$];

  // same probe order as the block: start at count/2, narrow [lo, hi)
  function automatic void search_table(input logic [DATA_W-1:0] key);
    int unsigned       n, lo, hi, probe;
    bit                matched;
    logic [DATA_W-1:0] probe_key;
    n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
    lo = 0;
    hi = n;
    probe = n / 2;
    matched = 1'b0;
    while (!matched && probe >= lo && probe < hi) begin
      probe_key = table_copy[probe][0];
      if (key == probe_key) begin
        matched = 1'b1;
      end else if (key < probe_key) begin
        hi = probe;
      end else begin
        lo = probe + 1;
      end
      if (!matched) begin
        probe = lo + (hi - lo) / 2;
      end
    end
    if (matched) begin
      for (int k = 0; k < RECORD_WORDS; k++) begin
        expected_words.push_back(result_word_t'{1'b1, WORD_IDX_W'(k), table_copy[probe][k],
                                                k == RECORD_WORDS - 1});
      end
      hits++;
    end else begin
      expected_words.push_back(result_word_t'{1'b0, '0, '0, 1'b1});
      misses++;
    end
  endfunction

  always @(posedge clk) begin
    result_word_t want, got;
    if (rst) begin
      entry_count = '0;
      expected_words.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = result_word_t'{out_ch.found, out_ch.word_position, out_ch.record_word,
                             out_ch.last};
        if (expected_words.size() == 0) begin
          $display("%0t: result transfer with nothing pending: found %0b pos %0d word %h last %0b",
                   $time, got.found, got.position, got.word, got.last);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found expected %0b got %0b", $time, want.found, got.found);
            errors++;
          end
          if (got.position !== want.position) begin
            $display("%0t: word_position expected %0d got %0d", $time, want.position,
                     got.position);
            errors++;
          end
          if (got.word !== want.word) begin
            $display("%0t: record_word expected %h got %h", $time, want.word, got.word);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.opcode == OP_WRITE) begin
          writes++;
          // word index past the record is dropped by the block
          if (in_ch.word_index < RECORD_WORDS) begin
            table_copy[in_ch.entry_index][in_ch.word_index] = in_ch.word_value;
          end
        end else begin
          search_table(in_ch.codepoint);
        end
      end
      if (cfg_wr_en) begin
        entry_count = cfg_wr_data;
      end
    end
    pending <= expected_words.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import srbs_pkg::*;

  localparam int LIMIT_CYCLES = 50000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;
  localparam int FILL_RECORDS = 6;
  localparam int SAT_ENTRY    = TABLE_DEPTH / 2;
  localparam int PHASE_ITEMS  = 8;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;

  srbs_in_if  in_ch ();
  srbs_out_if out_ch ();

  int errors, pending, hits, misses, writes;
  int send_idle_pct, recv_stall_pct;
  int eff_count, settings_seen, cycle_count;
  bit hold_go, hold_done;

  // keys as last written, used to aim lookups at existing records
  logic [DATA_W-1:0] key_of [TABLE_DEPTH];

  sorted_record_binary_search uut (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  record_lookup_checker lookup_check (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .errors      (errors),
    .pending     (pending),
    .hits        (hits),
    .misses      (misses),
    .writes      (writes)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send(input logic op, input logic [ENTRY_W-1:0] e,
                      input logic [WORD_IDX_W-1:0] w, input logic [DATA_W-1:0] val,
                      input logic [DATA_W-1:0] cp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.entry_index <= e;
    in_ch.word_index  <= w;
    in_ch.word_value  <= val;
    in_ch.codepoint   <= cp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_word(input int e, input int w, input logic [DATA_W-1:0] val);
    send(OP_WRITE, ENTRY_W'(e), WORD_IDX_W'(w), val, $urandom);
    if (w == 0) begin
      key_of[e] = val;
    end
  endtask

  task automatic lookup(input logic [DATA_W-1:0] cp);
    send(OP_LOOKUP, ENTRY_W'($urandom), WORD_IDX_W'($urandom), $urandom, cp);
  endtask

  // drop valid, wait for every pending result, then let the sequencer settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(input int v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= COUNT_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    eff_count = (v > TABLE_DEPTH) ? TABLE_DEPTH : v;
    settings_seen++;
  endtask

  // writes stay inside the filled records, so every probe lands on written words
  task automatic random_item();
    int                pick, e, w;
    logic [DATA_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 55 && eff_count > 0) begin
      lookup(key_of[$urandom_range(0, eff_count - 1)]);
    end else if (pick < 70 && eff_count > 0) begin
      v = key_of[$urandom_range(0, eff_count - 1)];
      lookup($urandom_range(0, 1) ? v + 32'd1 : v - 32'd1);
    end else if (pick < 80) begin
      lookup($urandom);
    end else begin
      e = $urandom_range(0, FILL_RECORDS - 1);
      w = $urandom_range(0, 15);
      // a fresh random key now and then leaves the table unsorted
      if (w == 0 && $urandom_range(0, 3) != 0) begin
        v = key_of[e];
      end else begin
        v = $urandom;
      end
      write_word(e, w, v);
    end
  endtask

  initial begin
    int                phase_counts [4];
    logic [DATA_W-1:0] key;
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_WRITE;
    in_ch.entry_index = '0;
    in_ch.word_index  = '0;
    in_ch.word_value  = '0;
    in_ch.codepoint   = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_go           = 1'b0;
    eff_count         = 0;
    settings_seen     = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // count is zero out of reset, so these must miss without probing
    lookup(32'h0000_0000);
    lookup(32'hffff_ffff);

    // fill the first records, keys strictly ascending from 0 to all ones
    for (int e = 0; e < FILL_RECORDS; e++) begin
      if (e == 0) begin
        key = '0;
      end else if (e == FILL_RECORDS - 1) begin
        key = '1;
      end else begin
        key = (DATA_W'(e) << 28) | DATA_W'($urandom_range(0, 28'hfff_ffff));
      end
      for (int w = 0; w < RECORD_WORDS; w++) begin
        write_word(e, w, (w == 0) ? key : $urandom);
      end
    end

    set_count(FILL_RECORDS);
    lookup(key_of[0]);
    lookup(key_of[FILL_RECORDS - 1]);
    lookup(key_of[2] + 32'd1);
    // word indexes past the record are dropped
    write_word(FILL_RECORDS - 1, RECORD_WORDS - 1, 32'h0000_0000);
    write_word(FILL_RECORDS - 1, RECORD_WORDS, $urandom);
    write_word(FILL_RECORDS - 1, 15, $urandom);
    lookup(key_of[FILL_RECORDS - 1]);
    // out-of-order key at the first probe position
    key = key_of[FILL_RECORDS / 2];
    write_word(FILL_RECORDS / 2, 0, 32'hffff_ffff);
    lookup(32'hffff_ffff);
    write_word(FILL_RECORDS / 2, 0, key);

    // full record at the first probe of a full-size table
    for (int w = 0; w < RECORD_WORDS; w++) begin
      write_word(SAT_ENTRY, w, $urandom);
    end
    set_count(2047);
    lookup(key_of[SAT_ENTRY]);
    set_count(TABLE_DEPTH + 1);
    lookup(key_of[SAT_ENTRY]);
    set_count(TABLE_DEPTH);
    lookup(key_of[SAT_ENTRY]);

    set_count(1);
    lookup(key_of[0]);
    lookup(key_of[1]);
    set_count(0);
    lookup(32'h0000_0000);

    phase_counts = '{FILL_RECORDS, 3, 2, 1};
    phase_counts[3] = $urandom_range(1, FILL_RECORDS);
    for (int p = 0; p < 4; p++) begin
      set_count(phase_counts[p]);
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 51;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 51;
        end
        default: begin
          send_idle_pct  = 37;
          recv_stall_pct = 37;
        end
      endcase
      repeat (PHASE_ITEMS) random_item();
    end

    // back-to-back lookups of written keys while the output is held off
    set_count(FILL_RECORDS);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b1;
    repeat (8) lookup(key_of[$urandom_range(0, FILL_RECORDS - 1)]);

    drain();
    $display("covered %0d lookups (%0d hits, %0d misses) and %0d writes",
             hits + misses, hits, misses, writes);
    $display("over %0d entry_count settings, four idle mixes and one long output hold",
             settings_seen);
    if (errors == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/srbs_pkg.sv
rtl/core/srbs_if.sv
rtl/core/srbs_store.sv
rtl/core/srbs_ctrl.sv
rtl/core/sorted_record_binary_search.sv
bench/record_lookup_checker.sv
bench/tb_top.sv
